### sv/stsw_pkg.sv
package stsw_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int DIGIT_W     = 2;
    localparam int SEG_W       = 8;
    localparam int TIME_W      = 17;
    localparam int BCD_W       = 4;

    // remainder widths after each decimal split
    localparam int REM0_W = 14;   // below 10000
    localparam int REM1_W = 10;   // below 1000
    localparam int REM2_W = 7;    // below 100

    localparam logic [TIME_W-1:0] TIME_LIMIT = 17'd99990;
    localparam logic [TIME_W-1:0] UNIT_10S   = 17'd10000;
    localparam logic [TIME_W-1:0] UNIT_1S    = 17'd1000;
    localparam logic [TIME_W-1:0] UNIT_100MS = 17'd100;
    localparam logic [TIME_W-1:0] UNIT_10MS  = 17'd10;

    localparam logic [BCD_W-1:0]  SAT_DIGIT0 = BCD_W'(TIME_LIMIT / UNIT_10S);
    localparam logic [REM0_W-1:0] SAT_REM0   = REM0_W'(TIME_LIMIT % UNIT_10S);

    localparam logic [SEG_W-1:0] POINT_BIT  = 8'b1000_0000;
    localparam logic [SEG_W-1:0] SEG_BLANK  = 8'b0000_0000;
    localparam int               POINT_DIGIT = 1;

    localparam logic CMD_SHOW  = 1'b0;
    localparam logic CMD_BLANK = 1'b1;

    localparam int DEF_QUEUE_DEPTH = 2;

    typedef logic [SEG_W-1:0] seg_t;

    // one run of digit writes: which digits change and their new bytes
    typedef struct packed {
        logic [DIGIT_COUNT-1:0] mask;
        seg_t [DIGIT_COUNT-1:0] bytes;
    } wr_run_t;

    // decimal digit of v for a given place value, v below ten places
    function automatic logic [BCD_W-1:0] dec_digit(input logic [TIME_W-1:0] v,
                                                   input logic [TIME_W-1:0] unit);
        logic [BCD_W-1:0] q;
        q = '0;
        for (int k = 1; k < 10; k++) begin
            if (v >= TIME_W'(k) * unit) begin
                q = BCD_W'(k);
            end
        end
        return q;
    endfunction

    function automatic seg_t seg_font(input logic [BCD_W-1:0] d);
        seg_t s;
        unique case (d)
            4'h0: s = 8'b0011_1111;
            4'h1: s = 8'b0000_0110;
            4'h2: s = 8'b0101_1011;
            4'h3: s = 8'b0100_1111;
            4'h4: s = 8'b0110_0110;
            4'h5: s = 8'b0110_1101;
            4'h6: s = 8'b0111_1101;
            4'h7: s = 8'b0000_0111;
            4'h8: s = 8'b0111_1111;
            4'h9: s = 8'b0110_1111;
            4'hA: s = 8'b0111_0111;
            4'hB: s = 8'b0111_1100;
            4'hC: s = 8'b0011_1001;
            4'hD: s = 8'b0101_1110;
            4'hE: s = 8'b0111_1001;
            4'hF: s = 8'b0111_0001;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

### sv/stopwatch_seven_segment_writer_core.sv
// stopwatch seven-segment writer
//
// input channel (s_valid/s_ready): one transfer per command. s_cmd selects
// show time (s_time_ms, clamped at 99.99 s) or blank all four digits.
// result channel (m_valid/m_ready): one transfer per digit whose segment
// byte differs from what was last sent, lowest digit index first, with
// m_last_of_run high on the final write of a command. a command that
// changes nothing produces no transfers.
//
// the first write of a command passes three decimal split stages, the
// queue push and the output register before it appears on m_valid.
// throughput: a command enters every cycle while the queue has room; the
// write sequencer emits one digit per cycle while m_ready is high, at
// most four digit writes per command.
//
// reset (aresetn low, synchronous) marks all digits as blank and empties
// the pipeline and queue. a stall on m_ready backs up the run queue; once
// it fills, s_ready drops and the front holds its contents.
module stopwatch_seven_segment_writer_core import stsw_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [TIME_W-1:0]  s_time_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DIGIT_W-1:0] m_digit_index,
    output logic [SEG_W-1:0]   m_segments,
    output logic               m_last_of_run
);

    // runs of changed digits between front and sequencer
    logic    push, pop, q_full, q_empty;
    wr_run_t push_run, head_run;

    // decimal split, font lookup, compare against shown bytes
    stsw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_time_ms (s_time_ms),
        .q_full    (q_full),
        .push      (push),
        .push_run  (push_run)
    );

    // short queue so a stalled receiver does not hold the front at once
    stsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .in_run  (push_run),
        .full    (q_full),
        .pop     (pop),
        .head    (head_run),
        .empty   (q_empty)
    );

    // one digit write per transfer from the registered output
    stsw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head_run),
        .empty         (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_index (m_digit_index),
        .m_segments    (m_segments),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### sv/stsw_front.sv
module stsw_front import stsw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [TIME_W-1:0] s_time_ms,
    input  logic              q_full,
    output logic              push,
    output wr_run_t           push_run
);

    logic adv;

    logic                a_valid_reg, b_valid_reg, c_valid_reg;
    logic                a_cmd_reg, b_cmd_reg, c_cmd_reg;
    logic [BCD_W-1:0]    a_d0_reg, b_d0_reg, c_d0_reg;
    logic [BCD_W-1:0]    b_d1_reg, c_d1_reg;
    logic [BCD_W-1:0]    c_d2_reg, c_d3_reg;
    logic [REM0_W-1:0]   a_rem_reg;
    logic [REM1_W-1:0]   b_rem_reg;
    seg_t [DIGIT_COUNT-1:0] shown_reg;

    logic                sat;
    logic [BCD_W-1:0]    d0_raw, a_d0_next, b_d1_next, c_d2_next, c_d3_next;
    logic [TIME_W-1:0]   rem0_full, rem1_full, rem2_full;
    logic [REM0_W-1:0]   a_rem_next;
    logic [REM1_W-1:0]   b_rem_next;
    seg_t [DIGIT_COUNT-1:0] want;
    logic [DIGIT_COUNT-1:0] diff;

    // the whole front moves together while the queue has room
    assign adv     = !q_full;
    assign s_ready = adv;

    // stage a: saturate and split off tens of seconds
    always_comb begin
        sat       = s_time_ms > TIME_LIMIT;
        d0_raw    = dec_digit(s_time_ms, UNIT_10S);
        rem0_full = s_time_ms - TIME_W'(d0_raw) * UNIT_10S;
        a_d0_next  = sat ? SAT_DIGIT0 : d0_raw;
        a_rem_next = sat ? SAT_REM0 : rem0_full[REM0_W-1:0];
    end

    // stage b: seconds
    always_comb begin
        b_d1_next  = dec_digit(TIME_W'(a_rem_reg), UNIT_1S);
        rem1_full  = TIME_W'(a_rem_reg) - TIME_W'(b_d1_next) * UNIT_1S;
        b_rem_next = rem1_full[REM1_W-1:0];
    end

    // stage c: tenths and hundredths
    always_comb begin
        c_d2_next = dec_digit(TIME_W'(b_rem_reg), UNIT_100MS);
        rem2_full = TIME_W'(b_rem_reg) - TIME_W'(c_d2_next) * UNIT_100MS;
        c_d3_next = dec_digit(TIME_W'(rem2_full[REM2_W-1:0]), UNIT_10MS);
    end

    // classify: font lookup and compare against what the display holds
    always_comb begin
        if (c_cmd_reg == CMD_BLANK) begin
            want = '0;
        end else begin
            want[0] = seg_font(c_d0_reg);
            want[1] = seg_font(c_d1_reg) | POINT_BIT;
            want[2] = seg_font(c_d2_reg);
            want[3] = seg_font(c_d3_reg);
        end
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            diff[i] = want[i] != shown_reg[i];
        end
    end

    assign push           = adv && c_valid_reg && (diff != '0);
    assign push_run.mask  = diff;
    assign push_run.bytes = want;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            shown_reg   <= '0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            if (c_valid_reg) begin
                shown_reg <= want;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_cmd_reg <= s_cmd;
            a_d0_reg  <= a_d0_next;
            a_rem_reg <= a_rem_next;
            b_cmd_reg <= a_cmd_reg;
            b_d0_reg  <= a_d0_reg;
            b_d1_reg  <= b_d1_next;
            b_rem_reg <= b_rem_next;
            c_cmd_reg <= b_cmd_reg;
            c_d0_reg  <= b_d0_reg;
            c_d1_reg  <= b_d1_reg;
            c_d2_reg  <= c_d2_next;
            c_d3_reg  <= c_d3_next;
        end
    end

endmodule

### sv/stsw_queue.sv
module stsw_queue import stsw_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  wr_run_t in_run,
    output logic    full,
    input  logic    pop,
    output wr_run_t head,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wr_run_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_run;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("run pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("run popped from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### sv/stsw_back.sv
module stsw_back import stsw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  wr_run_t            head,
    input  logic               empty,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DIGIT_W-1:0] m_digit_index,
    output logic [SEG_W-1:0]   m_segments,
    output logic               m_last_of_run
);

    logic                   busy_reg;
    logic [DIGIT_COUNT-1:0] cur_mask_reg;
    seg_t [DIGIT_COUNT-1:0] cur_bytes_reg;
    logic                   m_valid_reg, m_last_reg;
    logic [DIGIT_W-1:0]     m_idx_reg;
    seg_t                   m_seg_reg;

    logic                   load, have;
    logic [DIGIT_COUNT-1:0] src_mask, rest;
    seg_t [DIGIT_COUNT-1:0] src_bytes;
    logic [DIGIT_W-1:0]     pick;

    assign load = !m_valid_reg || m_ready;
    assign have = busy_reg || !empty;
    assign pop  = load && !busy_reg && !empty;

    // lowest changed digit goes first
    always_comb begin
        src_mask  = busy_reg ? cur_mask_reg  : head.mask;
        src_bytes = busy_reg ? cur_bytes_reg : head.bytes;
        pick = '0;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            if (src_mask[i]) begin
                pick = DIGIT_W'(i);
            end
        end
        rest       = src_mask;
        rest[pick] = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            cur_mask_reg <= '0;
        end else if (load) begin
            m_valid_reg <= have;
            if (have) begin
                busy_reg     <= rest != '0;
                cur_mask_reg <= rest;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && have) begin
            m_idx_reg  <= pick;
            m_seg_reg  <= src_bytes[pick];
            m_last_reg <= rest == '0;
            if (!busy_reg) begin
                cur_bytes_reg <= head.bytes;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digit_index = m_idx_reg;
    assign m_segments    = m_seg_reg;
    assign m_last_of_run = m_last_reg;

`ifndef NO_ASSERTIONS
    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cur_mask_reg != '0)
        else $error("sequencer busy with no digits left");
`endif

endmodule

### verif/stopwatch_seven_segment_writer_core_tb.sv
module stopwatch_seven_segment_writer_core_tb;
    import stsw_pkg::*;

    // one digit write as seen on the result channel
    typedef struct {
        logic [DIGIT_W-1:0] digit;
        seg_t               seg;
        logic               last;
    } digit_write_t;

    // glyphs for the decimal digits a time can produce (a..g in bits 0..6)
    localparam seg_t DIGIT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // tracks what the display shows and which writes each command must cause
    class digit_write_scoreboard;
        seg_t         shown [DIGIT_COUNT];
        digit_write_t pending_writes [$];
        int commands_noted;
        int blanks_noted;
        int clamped_noted;
        int writes_checked;
        int mismatches;

        function new();
            foreach (shown[i]) shown[i] = SEG_BLANK;
            commands_noted = 0;
            blanks_noted   = 0;
            clamped_noted  = 0;
            writes_checked = 0;
            mismatches     = 0;
        endfunction

        // bytes the display should hold after this command
        function void glyphs_for(input logic cmd, input logic [TIME_W-1:0] ms,
                                 output seg_t want [DIGIT_COUNT]);
            int t;
            if (cmd == CMD_BLANK) begin
                foreach (want[i]) want[i] = SEG_BLANK;
                return;
            end
            t = int'(ms);
            if (t > int'(TIME_LIMIT)) begin
                t = int'(TIME_LIMIT);
            end
            want[0] = DIGIT_GLYPH[t / 10000];
            want[1] = DIGIT_GLYPH[(t % 10000) / 1000] | POINT_BIT;
            want[2] = DIGIT_GLYPH[(t % 1000) / 100];
            want[3] = DIGIT_GLYPH[(t % 100) / 10];
        endfunction

        function void note_command(input logic cmd, input logic [TIME_W-1:0] ms);
            seg_t         want [DIGIT_COUNT];
            digit_write_t wr;
            int           changed [$];
            glyphs_for(cmd, ms, want);
            commands_noted++;
            if (cmd == CMD_BLANK) blanks_noted++;
            else if (ms > TIME_LIMIT) clamped_noted++;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (want[i] != shown[i]) changed.push_back(i);
            end
            // only changed digits go out, lowest index first
            foreach (changed[k]) begin
                wr.digit = DIGIT_W'(changed[k]);
                wr.seg   = want[changed[k]];
                wr.last  = (k == changed.size() - 1);
                pending_writes.push_back(wr);
                shown[changed[k]] = want[changed[k]];
            end
        endfunction

        function void check_write(input logic [DIGIT_W-1:0] digit, input seg_t seg,
                                  input logic last);
            digit_write_t exp_wr;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected write: digit %0d seg %02h last %0b",
                             digit, seg, last);
                end
                return;
            end
            exp_wr = pending_writes.pop_front();
            writes_checked++;
            if (digit !== exp_wr.digit || seg !== exp_wr.seg || last !== exp_wr.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("write mismatch: expected digit %0d seg %02h last %0b, ",
                             exp_wr.digit, exp_wr.seg, exp_wr.last,
                             "got digit %0d seg %02h last %0b",
                             digit, seg, last);
                end
            end
        endfunction

        function int pending_count();
            return pending_writes.size();
        endfunction
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_cmd         = CMD_SHOW;
    logic [TIME_W-1:0]  s_time_ms     = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [DIGIT_W-1:0] m_digit_index;
    logic [SEG_W-1:0]   m_segments;
    logic               m_last_of_run;

    digit_write_scoreboard sb = new();

    // idling controls, switched per phase
    bit send_idle_on = 1'b0;
    bit rx_calm      = 1'b1;
    int rx_hold      = 0;
    int lap_ms       = 0;

    stopwatch_seven_segment_writer_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_index (m_digit_index),
        .m_segments    (m_segments),
        .m_last_of_run (m_last_of_run)
    );

    always #6 aclk = ~aclk;

    // monitor: values read here are the ones from just before the edge.
    // the result side is checked first so a transfer on the same edge never
    // matches a write that the incoming command has only just queued
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_write(m_digit_index, m_segments, m_last_of_run);
            if (s_valid && s_ready) sb.note_command(s_cmd, s_time_ms);
        end
    end

    // result side backpressure: runs of ready broken by stalls, short mostly
    always @(posedge aclk) begin
        if (rx_calm) begin
            m_ready <= 1'b1;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if ($urandom_range(0, 99) < 40) begin
            m_ready <= 1'b0;
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
            rx_hold = $urandom_range(0, 8);
        end
    end

    // present one command and hold it until the transfer happens
    task automatic send_command(input logic cmd, input logic [TIME_W-1:0] ms);
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_time_ms <= ms;
        do @(posedge aclk); while (!s_ready);
    endtask

    // optional gap after a transfer, mostly none or short, now and then long
    task automatic idle_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (!send_idle_on || r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold off input until the display has caught up with everything sent
    task automatic wait_display_settled();
        s_valid <= 1'b0;
        // let the monitor note the last transfer before looking at the backlog
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic show_time(input int ms);
        send_command(CMD_SHOW, TIME_W'(ms));
        idle_sender();
    endtask

    task automatic random_commands(input int count, input bit with_pause);
        int r;
        int t;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // running stopwatch: small steps touch only the low digits
                lap_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3000)
                                                      : $urandom_range(1, 250);
                if (lap_ms > 131071) lap_ms = $urandom_range(0, 2000);
                send_command(CMD_SHOW, TIME_W'(lap_ms));
            end else if (r < 55) begin
                // blank, time field is don't care
                send_command(CMD_BLANK, TIME_W'($urandom));
            end else if (r < 63) begin
                // lap time again, which changes nothing if it is still shown
                send_command(CMD_SHOW, TIME_W'(lap_ms));
            end else if (r < 80) begin
                send_command(CMD_SHOW, TIME_W'($urandom_range(0, 131071)));
            end else if (r < 90) begin
                // above the limit, shown as saturated
                send_command(CMD_SHOW, TIME_W'($urandom_range(99991, 131071)));
            end else begin
                // around decimal rollovers
                case ($urandom_range(0, 4))
                    0: t = 9;
                    1: t = 99;
                    2: t = 999;
                    3: t = 9999;
                    default: t = 99989;
                endcase
                send_command(CMD_SHOW, TIME_W'(t + $urandom_range(0, 2)));
            end
            idle_sender();
            if (with_pause && i == count / 2) wait_display_settled();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: blank right after reset is a no-op, then every glyph,
        // decimal rollovers, saturation and repeats that change nothing
        send_command(CMD_BLANK, '1);
        idle_sender();
        show_time(0);
        show_time(0);
        show_time(12340);
        show_time(56780);
        show_time(90000);
        show_time(5);
        show_time(9);
        show_time(10);
        show_time(99);
        show_time(100);
        show_time(999);
        show_time(1000);
        show_time(9999);
        show_time(10000);
        show_time(99989);
        show_time(99990);
        show_time(99991);
        show_time(131071);
        show_time(65536);
        show_time(17'h0AAAA);
        show_time(17'h15555);
        send_command(CMD_BLANK, 17'h15555);
        idle_sender();
        send_command(CMD_BLANK, '0);
        idle_sender();
        wait_display_settled();

        // random: first with no idling, then idling on both sides with a
        // full drain in the middle, then heavy result-side stalls only
        random_commands(30, 1'b0);
        send_idle_on = 1'b1;
        rx_calm      = 1'b0;
        random_commands(40, 1'b1);
        send_idle_on = 1'b0;
        random_commands(30, 1'b0);

        wait_display_settled();
        repeat (20) @(posedge aclk);

        $display("covered %0d commands (%0d blank, %0d above the limit), ",
                 sb.commands_noted, sb.blanks_noted, sb.clamped_noted,
                 "%0d digit writes checked", sb.writes_checked);
        if (sb.pending_count() != 0) begin
            $display("%0d expected writes never arrived", sb.pending_count());
        end
        if (sb.mismatches != 0) begin
            $display("%0d write mismatches", sb.mismatches);
        end
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #3600000;
        $display("timeout with %0d writes outstanding", sb.pending_count());
        $display("TEST FAILED");
        $finish;
    end

endmodule
